// ===== sv/xmodem_frame_receiver_top_defines.svh =====
// ---------------------------------------------------------------------------
// XMODEM frame receiver assertion macros
// Short forms for the concurrent checks in the receiver.
// ---------------------------------------------------------------------------
`ifndef XMODEM_FRAME_RECEIVER_TOP_DEFINES_SVH
`define XMODEM_FRAME_RECEIVER_TOP_DEFINES_SVH

// plain invariant, sampled on clk, off during reset
`define XFR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define XFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define XFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/xfr_pkg.sv =====
// ---------------------------------------------------------------------------
// XMODEM frame receiver package
// Control byte codes, default parameters and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xfr_pkg;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;

    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;

    localparam logic RESULT_WRITE = 1'b0;
    localparam logic RESULT_REPLY = 1'b1;

    localparam logic REPLY_ACK = 1'b0;
    localparam logic REPLY_NAK = 1'b1;

    localparam int DEF_FRAMES_PER_PAGE = 2;
    localparam int DEF_SLOT_COUNT      = 4;
    localparam int DEF_CHECK_BYTES     = 1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [10:0] write_offset;
        logic [1:0]  page_slot;
        logic        reply_code;
        logic        page_ready;
        logic        transfer_end;
    } xfr_result_t;

endpackage

// ===== sv/xmodem_frame_receiver_top.sv =====
// ---------------------------------------------------------------------------
// XMODEM frame receiver
// Parses XMODEM / XMODEM-1K frames byte by byte, emits page-buffer writes
// and ACK/NAK replies.
// ---------------------------------------------------------------------------
// Input channel: one received serial byte per request (rx_byte, in_valid,
// in_stall). Output channel: one result per request that causes one:
// either a page-buffer write (data_byte, write_offset, page_slot) or a
// reply (reply_code, page_ready, transfer_end), told apart by result_kind.
// Bytes that cause nothing (headers, ignored bytes) give no output request.
// With the output free, a result is presented the cycle after its byte is
// accepted; a stalled output holds the result until it is taken.
// Throughput: one byte per cycle while in_stall is low; the whole parse step
// is a single combinational update between the state and result registers.
// An output register plus one skid entry sit between the channels, so a
// byte is still accepted while a result waits; in_stall rises only once the
// skid entry is also occupied, and drops the cycle after the output is taken.
// Reset: hunting for a start byte, sequence number 0, page slot 0, output
// empty. After EOT is answered every byte is accepted and dropped until
// the next reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_frame_receiver_top_defines.svh"

module xmodem_frame_receiver_top
    import xfr_pkg::*;
#(
    parameter int FRAMES_PER_PAGE = DEF_FRAMES_PER_PAGE,
    parameter int SLOT_COUNT      = DEF_SLOT_COUNT,
    parameter int CHECK_BYTES     = DEF_CHECK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic [10:0] write_offset,
    output logic [1:0]  page_slot,
    output logic        reply_code,
    output logic        page_ready,
    output logic        transfer_end
);

    localparam int PW = (FRAMES_PER_PAGE > 1) ? $clog2(FRAMES_PER_PAGE) : 1;
    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [PW-1:0]  POS_LAST  = PW'(FRAMES_PER_PAGE - 1);
    localparam logic [SW-1:0]  SLOT_LAST = SW'(SLOT_COUNT - 1);
    localparam logic [10:0]    CHECK_N   = 11'(CHECK_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SEQ,
        PH_CMP,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        ST_READY,
        ST_DOWNLOAD,
        ST_DONE
    } stage_t;

    phase_t        phase_reg, phase_next;
    stage_t        stage_reg, stage_next;
    logic          long_reg, long_next;
    logic [10:0]   count_reg, count_next;
    logic [7:0]    seq_reg, seq_next;
    logic          hdr_good_reg, hdr_good_next;
    logic [7:0]    sum_reg, sum_next;
    logic [SW-1:0] slot_reg, slot_next;
    // last good sequence number modulo FRAMES_PER_PAGE
    logic [PW-1:0] pos_reg, pos_next;

    xfr_result_t   out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    xfr_result_t   skid_reg, skid_next;
    logic          skid_valid_reg, skid_valid_next;

    xfr_result_t   res;
    logic          res_valid;
    logic          accept;
    logic          pop;
    logic [7:0]    seq_inc;
    logic [10:0]   cnt_inc;
    logic [10:0]   frame_len;
    logic          good_tmp;
    logic          ready_tmp;
    logic [PW-1:0] pos_new;
    logic [PW+9:0] off_wide;
    logic [SW-1:0] slot_inc;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid_reg && !out_stall;
    assign seq_inc   = seq_reg + 8'd1;
    assign cnt_inc   = count_reg + 11'd1;
    assign frame_len = long_reg ? LEN_LONG : LEN_SHORT;
    assign off_wide  = {pos_reg, count_reg[9:0]};
    assign slot_inc  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        stage_next    = stage_reg;
        long_next     = long_reg;
        count_next    = count_reg;
        seq_next      = seq_reg;
        hdr_good_next = hdr_good_reg;
        sum_next      = sum_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        res           = '0;
        res_valid     = 1'b0;
        good_tmp      = hdr_good_reg;
        ready_tmp     = 1'b0;
        pos_new       = pos_reg;

        if (accept && stage_reg != ST_DONE)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == BYTE_SOH || rx_byte == BYTE_STX)
                    begin
                        long_next  = (rx_byte == BYTE_STX);
                        phase_next = PH_SEQ;
                    end
                    else if (rx_byte == BYTE_EOT)
                    begin
                        // flush a partial page
                        ready_tmp          = (pos_reg != '0);
                        res.result_kind    = RESULT_REPLY;
                        res.page_slot      = 2'(slot_reg);
                        res.reply_code     = REPLY_ACK;
                        res.page_ready     = ready_tmp;
                        res.transfer_end   = 1'b1;
                        res_valid          = 1'b1;
                        if (ready_tmp)
                            slot_next = slot_inc;
                        stage_next = ST_DONE;
                    end
                end
                PH_SEQ:
                begin
                    hdr_good_next = (rx_byte == seq_inc);
                    phase_next    = PH_CMP;
                end
                PH_CMP:
                begin
                    good_tmp      = hdr_good_reg && (rx_byte == ~seq_inc);
                    hdr_good_next = good_tmp;
                    if (good_tmp && stage_reg == ST_READY)
                        stage_next = ST_DOWNLOAD;
                    count_next = '0;
                    sum_next   = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (cnt_inc >= frame_len)
                    begin
                        count_next = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                        count_next = cnt_inc;
                    if (hdr_good_reg)
                    begin
                        res.result_kind  = RESULT_WRITE;
                        res.data_byte    = rx_byte;
                        res.write_offset = off_wide[10:0];
                        res.page_slot    = 2'(slot_reg);
                        res_valid        = 1'b1;
                    end
                end
                PH_CHECK:
                begin
                    // only the first check byte is compared
                    if (count_reg == '0 && rx_byte != sum_reg)
                        good_tmp = 1'b0;
                    hdr_good_next = good_tmp;
                    if (cnt_inc < CHECK_N)
                        count_next = cnt_inc;
                    else
                    begin
                        count_next       = '0;
                        phase_next       = PH_HUNT;
                        res.result_kind  = RESULT_REPLY;
                        res.page_slot    = 2'(slot_reg);
                        res_valid        = 1'b1;
                        if (good_tmp)
                        begin
                            seq_next = seq_inc;
                            // sequence wrap lands back on page position zero
                            if (seq_reg == 8'hFF || pos_reg == POS_LAST)
                                pos_new = '0;
                            else
                                pos_new = pos_reg + PW'(1);
                            pos_next       = pos_new;
                            ready_tmp      = (pos_new == '0);
                            res.reply_code = REPLY_ACK;
                            res.page_ready = ready_tmp;
                            if (ready_tmp)
                                slot_next = slot_inc;
                        end
                        else
                            res.reply_code = REPLY_NAK;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            stage_reg      <= ST_READY;
            long_reg       <= 1'b0;
            count_reg      <= '0;
            seq_reg        <= '0;
            hdr_good_reg   <= 1'b0;
            sum_reg        <= '0;
            slot_reg       <= '0;
            pos_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_reg       <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            long_reg       <= long_next;
            count_reg      <= count_next;
            seq_reg        <= seq_next;
            hdr_good_reg   <= hdr_good_next;
            sum_reg        <= sum_next;
            slot_reg       <= slot_next;
            pos_reg        <= pos_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            skid_reg       <= skid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_reg.result_kind;
    assign data_byte    = out_reg.data_byte;
    assign write_offset = out_reg.write_offset;
    assign page_slot    = out_reg.page_slot;
    assign reply_code   = out_reg.reply_code;
    assign page_ready   = out_reg.page_ready;
    assign transfer_end = out_reg.transfer_end;

    `XFR_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid ahead of output")
    `XFR_ASSERT_NXT(a_done_sticks, stage_reg == ST_DONE, stage_reg == ST_DONE, "left done")
    `XFR_ASSERT_IMP(a_done_silent, accept && stage_reg == ST_DONE, !res_valid, "late result")
    `XFR_ASSERT_IMP(a_ready_reply, page_ready, result_kind == RESULT_REPLY, "ready in a write")
    `XFR_ASSERT_IMP(a_ready_ack, page_ready, reply_code == REPLY_ACK, "ready in a NAK")
    `XFR_ASSERT(a_pos_range, pos_reg <= POS_LAST, "page position out of range")

endmodule
